/* hw/rtl/postfix_stack_evaluator_core_defines.svh */
// Assertion macros for the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`ifndef NO_ASSERTIONS
`define PSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("postfix evaluator: same-cycle check failed");
`define PSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("postfix evaluator: next-cycle check failed");
`else
`define PSE_ASSERT_IMP(lbl, ante, cons)
`define PSE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/pse_pkg.sv */
// Shared types and constants of the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

  localparam int SymWidth      = 8;
  localparam int ValueOutWidth = 32;
  localparam int StatusWidth   = 3;

  localparam logic [SymWidth-1:0] SymEnd  = 8'h24;  // '$'
  localparam logic [SymWidth-1:0] SymZero = 8'h30;  // '0'
  localparam logic [SymWidth-1:0] SymNine = 8'h39;  // '9'
  localparam logic [SymWidth-1:0] SymAdd  = 8'h2B;  // '+'
  localparam logic [SymWidth-1:0] SymSub  = 8'h2D;  // '-'
  localparam logic [SymWidth-1:0] SymMul  = 8'h2A;  // '*'

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_END_READ,
    S_EMIT,
    S_OP_READ_R,
    S_OP_READ_L,
    S_OP_EXEC,
    S_OP_WAIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_sym;
    logic    push_digit;
    logic    raise_err;
    status_e err_code;
    logic    rd_top;
    logic    rd_next;
    logic    cap_right;
    logic    cap_left;
    logic    alu_start;
    logic    write_result;
    logic    emit;
  } pse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_digit;
    logic is_end;
    logic sp_empty;
    logic sp_lt2;
    logic sp_full;
    logic out_free;
    logic alu_done;
  } pse_status_t;

endpackage

/* hw/rtl/pse_if.sv */
// Valid/ready channel interfaces for symbols in and results out.
`timescale 1ns / 1ps

interface pse_sym_if import pse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SymWidth-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface pse_res_if import pse_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [ValueOutWidth-1:0] value;
  logic [StatusWidth-1:0]        status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* hw/rtl/pse_alu.sv */
// Arithmetic unit: registered add/subtract, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module pse_alu import pse_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  alu_op_e                op_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] result_o,
  output logic                   div_zero_o
);

  localparam int CntWidth = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, fin_q, done_q, dz_q, neg_q;
  alu_op_e                op_q;
  logic [CntWidth-1:0]    cnt_q;
  logic [VALUE_WIDTH-1:0] result_q, mcand_q, mplier_q, quo_q, dvsr_q, rem_q;

  logic [VALUE_WIDTH-1:0] mag_a, mag_b;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH+1:0] diff;
  logic                   ge;

  assign mag_a  = a_i[VALUE_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b  = b_i[VALUE_WIDTH-1] ? (~b_i + 1'b1) : b_i;
  assign rem_sh = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvsr_q};
  assign ge     = ~diff[VALUE_WIDTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (op_i == ALU_MUL || (op_i == ALU_DIV && b_i != '0)) begin
          busy_q <= 1'b1;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q && cnt_q == CntWidth'(1)) begin
        busy_q <= 1'b0;
        if (op_q == ALU_DIV) begin
          fin_q <= 1'b1;
        end else begin
          done_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q     <= op_i;
      dz_q     <= 1'b0;
      cnt_q    <= CntWidth'(VALUE_WIDTH);
      mcand_q  <= a_i;
      mplier_q <= b_i;
      rem_q    <= '0;
      quo_q    <= mag_a;
      dvsr_q   <= mag_b;
      neg_q    <= a_i[VALUE_WIDTH-1] ^ b_i[VALUE_WIDTH-1];
      case (op_i)
        ALU_ADD: result_q <= a_i + b_i;
        ALU_SUB: result_q <= a_i - b_i;
        ALU_MUL: result_q <= '0;
        default: begin
          result_q <= '0;
          dz_q     <= (b_i == '0);
        end
      endcase
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntWidth'(1);
      if (op_q == ALU_MUL) begin
        if (mplier_q[0]) begin
          result_q <= result_q + mcand_q;
        end
        mcand_q  <= {mcand_q[VALUE_WIDTH-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[VALUE_WIDTH-1:1]};
      end else begin
        rem_q <= ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
      end
    end else if (fin_q) begin
      result_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
    end
  end

  assign done_o     = done_q;
  assign result_o   = result_q;
  assign div_zero_o = dz_q;

endmodule

/* hw/rtl/pse_datapath.sv */
// Datapath: operand stack memory, stack pointer, sticky error and result register.
`timescale 1ns / 1ps

module pse_datapath import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [SymWidth-1:0]             sym_i,
  input  pse_cmd_t                        cmd_i,
  output pse_status_t                     status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic signed [ValueOutWidth-1:0] out_value_o,
  output logic [StatusWidth-1:0]          out_status_o
);

  localparam int AddrWidth = $clog2(STACK_DEPTH);
  localparam int SpWidth   = $clog2(STACK_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q, right_q, left_q;
  logic [SymWidth-1:0]    sym_q;
  logic [SpWidth-1:0]     sp_q, sp_m1, sp_m2;
  status_e                err_q;

  logic                   out_valid_q;
  logic [ValueOutWidth-1:0] out_value_q;
  status_e                out_status_q;

  logic                   wr_en, rd_en;
  logic [AddrWidth-1:0]   wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data, digit_val;
  logic [SymWidth-1:0]    digit_raw;
  alu_op_e                alu_op;
  logic                   alu_done, alu_dz;
  logic [VALUE_WIDTH-1:0] alu_result;
  logic [VALUE_WIDTH+ValueOutWidth-1:0] top_ext;

  assign sp_m1 = sp_q - SpWidth'(1);
  assign sp_m2 = sp_q - SpWidth'(2);

  assign digit_raw = sym_q - SymZero;
  assign digit_val = VALUE_WIDTH'(digit_raw[3:0]);

  always_comb begin
    case (sym_q)
      SymAdd:  alu_op = ALU_ADD;
      SymSub:  alu_op = ALU_SUB;
      SymMul:  alu_op = ALU_MUL;
      default: alu_op = ALU_DIV;
    endcase
  end

  // Pushed digits land at the pointer, operator results where the left operand was.
  assign wr_en   = cmd_i.push_digit | cmd_i.write_result;
  assign wr_addr = cmd_i.push_digit ? sp_q[AddrWidth-1:0] : sp_m2[AddrWidth-1:0];
  assign wr_data = cmd_i.push_digit ? digit_val : alu_result;
  assign rd_en   = cmd_i.rd_top | cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_next ? sp_m2[AddrWidth-1:0] : sp_m1[AddrWidth-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sym) begin
      sym_q <= sym_i;
    end
    if (cmd_i.cap_right) begin
      right_q <= rd_data_q;
    end
    if (cmd_i.cap_left) begin
      left_q <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      err_q <= ST_OK;
    end else if (cmd_i.emit) begin
      sp_q  <= '0;
      err_q <= ST_OK;
    end else begin
      if (cmd_i.push_digit) begin
        sp_q <= sp_q + SpWidth'(1);
      end else if (cmd_i.write_result) begin
        sp_q <= sp_m1;
      end
      if (err_q == ST_OK) begin
        if (cmd_i.raise_err) begin
          err_q <= cmd_i.err_code;
        end else if (cmd_i.write_result && alu_dz) begin
          err_q <= ST_DIVZERO;
        end
      end
    end
  end

  pse_alu #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.alu_start),
    .op_i      (alu_op),
    .a_i       (left_q),
    .b_i       (right_q),
    .done_o    (alu_done),
    .result_o  (alu_result),
    .div_zero_o(alu_dz)
  );

  // Sign-extend the stack entry, then keep the low bits of the result field.
  assign top_ext = {{ValueOutWidth{rd_data_q[VALUE_WIDTH-1]}}, rd_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (sp_q == '0) begin
        out_value_q  <= '0;
        out_status_q <= (err_q != ST_OK) ? err_q : ST_EMPTY;
      end else begin
        out_value_q  <= top_ext[ValueOutWidth-1:0];
        out_status_q <= err_q;
      end
    end
  end

  always_comb begin
    status_o.is_digit = sym_q inside {[SymZero:SymNine]};
    status_o.is_end   = (sym_q == SymEnd);
    status_o.sp_empty = (sp_q == '0);
    status_o.sp_lt2   = (sp_q < SpWidth'(2));
    status_o.sp_full  = (sp_q == SpWidth'(STACK_DEPTH));
    status_o.out_free = ~out_valid_q | out_ready_i;
    status_o.alu_done = alu_done;
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

/* hw/rtl/pse_controller.sv */
// Controller: sequences stack reads, arithmetic and result emission per symbol.
`timescale 1ns / 1ps

module pse_controller import pse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pse_status_t status_i,
  output pse_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_sym = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.is_digit) begin
          if (status_i.sp_full) begin
            cmd_o.raise_err = 1'b1;
            cmd_o.err_code  = ST_OVERFLOW;
          end else begin
            cmd_o.push_digit = 1'b1;
          end
          state_d = S_IDLE;
        end else if (status_i.is_end) begin
          if (status_i.sp_empty) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.rd_top = 1'b1;
            state_d      = S_END_READ;
          end
        end else if (status_i.sp_lt2) begin
          cmd_o.raise_err = 1'b1;
          cmd_o.err_code  = ST_UNDERFLOW;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = S_OP_READ_R;
        end
      end
      S_END_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_OP_READ_R: begin
        cmd_o.cap_right = 1'b1;
        cmd_o.rd_next   = 1'b1;
        state_d         = S_OP_READ_L;
      end
      S_OP_READ_L: begin
        cmd_o.cap_left = 1'b1;
        state_d        = S_OP_EXEC;
      end
      S_OP_EXEC: begin
        cmd_o.alu_start = 1'b1;
        state_d         = S_OP_WAIT;
      end
      S_OP_WAIT: begin
        if (status_i.alu_done) begin
          cmd_o.write_result = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/postfix_stack_evaluator_core.sv */
// Postfix stack evaluator top level: one symbol beat in, one result beat per '$'.
// A digit or an operator short of operands is settled at dispatch. '+', '-' and a divide by
// zero skip the iteration of the one-bit-per-cycle ALU, which '*' and a nonzero divide use.
// Symbols are taken one at a time; a '$' also waits while the output register holds an
// unaccepted result.
// Reset (rst_ni low, asynchronous) empties the stack, clears the error and drops the output.
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_core_defines.svh"

module postfix_stack_evaluator_core import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic      clk_i,
  input logic      rst_ni,
  pse_sym_if.sink  sym_i,
  pse_res_if.source res_o
);

  // The controller and datapath talk only through these two structs. The
  // controller owns the input handshake; the datapath owns the output
  // register, so a finished result never blocks the next symbol beat unless
  // that symbol is itself another '$'.
  pse_cmd_t    ctrl_cmd;
  pse_status_t dp_status;

  pse_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(sym_i.valid),
    .in_ready_o(sym_i.ready),
    .status_i  (dp_status),
    .cmd_o     (ctrl_cmd)
  );

  // The stack is a single-port-read memory, so an operator reads its right
  // operand and then its left one on consecutive cycles before the ALU starts.
  pse_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_i       (sym_i.symbol),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_value_o (res_o.value),
    .out_status_o(res_o.status)
  );

  // A result is only loaded when the output register is free or draining.
  `PSE_ASSERT_IMP(a_emit_slot_free, ctrl_cmd.emit, dp_status.out_free)
  // A digit is never written past the last stack entry.
  `PSE_ASSERT_IMP(a_push_not_full, ctrl_cmd.push_digit, !dp_status.sp_full)
  // Loading a result always presents it on the next cycle.
  `PSE_ASSERT_NEXT(a_emit_shows_result, ctrl_cmd.emit, res_o.valid)
  // After a symbol beat the controller is busy decoding it.
  `PSE_ASSERT_NEXT(a_symbol_busy, sym_i.valid && sym_i.ready, !sym_i.ready)

endmodule
